>>> rtl/agdv_pkg.sv
// Shared types, constants and AES/GHASH helper functions for the GCM
// decrypt-and-verify unit. Depends on nothing; every module imports it.
package agdv_pkg;

  // Width of the wrapping part of the 32-bit counter field.
  localparam int COUNT_BITS = 32;
  localparam logic [31:0] CTR_MASK = 32'((64'(1) << COUNT_BITS) - 64'(1));

  localparam int QDEPTH = 2;
  localparam logic [3:0] AES_ROUNDS = 4'd10;
  localparam int GH_DIGIT = 8;
  localparam logic [4:0] GH_CYCLES = 5'(128 / GH_DIGIT);
  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] GH_POLY = 8'he1;
  localparam logic [7:0] RCON_FIRST = 8'h02 >> 1;

  localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
  localparam logic [2:0] CFG_KEY_LOW = 3'd1;
  localparam logic [2:0] CFG_NONCE_HIGH = 3'd2;
  localparam logic [2:0] CFG_NONCE_LOW = 3'd3;
  localparam logic [2:0] CFG_TAG_HIGH = 3'd4;
  localparam logic [2:0] CFG_TAG_LOW = 3'd5;

  typedef struct packed {
    logic [127:0] cipher;
    logic last;
    logic [31:0] count;
  } item_t;

  typedef struct packed {
    logic [127:0] plain;
    logic msg_end;
    logic match;
  } result_t;

  typedef struct packed {
    logic rekey_busy;
    logic [1:0] oq_count;
  } back_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next AES-128 round key from the current one.
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t = sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h0};
    n0 = rk[127:96] ^ t;
    n1 = n0 ^ rk[95:64];
    n2 = n1 ^ rk[63:32];
    n3 = n2 ^ rk[31:0];
    return {n0, n1, n2, n3};
  endfunction

  // One AES round; byte 0 is the most significant byte of the state.
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) t[r+4*c] = s[r+4*((c+r)&3)];
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = fin ? t[i] : m[i];
    return o ^ rk;
  endfunction

endpackage

>>> rtl/agdv_aes.sv
// Iterative AES-128 encryption core, one round per cycle, round keys
// expanded on the fly. Depends on agdv_pkg.
module agdv_aes (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] block_i,
  input  logic [127:0] key_i,
  output logic         done_o,
  output logic [127:0] result_o
);
  import agdv_pkg::*;

  logic [127:0] st_q, rk_q, nrk;
  logic [7:0] rcon_q;
  logic [3:0] rnd_q;
  logic done_q;

  assign nrk = key_next(rk_q, rcon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rnd_q <= 4'd1;
      end else if (rnd_q != '0) begin
        if (rnd_q == AES_ROUNDS) begin
          rnd_q <= '0;
          done_q <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q <= block_i ^ key_i;
      rk_q <= key_i;
      rcon_q <= RCON_FIRST;
    end else if (rnd_q != '0) begin
      st_q <= aes_round(st_q, nrk, rnd_q == AES_ROUNDS);
      rk_q <= nrk;
      rcon_q <= xtime(rcon_q);
    end
  end

  assign done_o = done_q;
  assign result_o = st_q;
endmodule

>>> rtl/agdv_ghash.sv
// Digit-serial GF(2^128) multiplier for GHASH, eight operand bits a cycle.
// Depends on agdv_pkg.
module agdv_ghash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] x_i,
  input  logic [127:0] h_i,
  output logic         done_o,
  output logic [127:0] z_o
);
  import agdv_pkg::*;

  logic [127:0] x_q, z_q, v_q, x_d, z_d, v_d;
  logic [4:0] cnt_q;
  logic done_q;

  // Operand bits are taken most significant first; V is multiplied by x each bit.
  always_comb begin
    x_d = x_q;
    z_d = z_q;
    v_d = v_q;
    for (int i = 0; i < GH_DIGIT; i++) begin
      if (x_d[127]) z_d = z_d ^ v_d;
      v_d = {1'b0, v_d[127:1]} ^ (v_d[0] ? {GH_POLY, 120'h0} : 128'h0);
      x_d = {x_d[126:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= GH_CYCLES;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      z_q <= '0;
      v_q <= h_i;
    end else if (cnt_q != '0) begin
      x_q <= x_d;
      z_q <= z_d;
      v_q <= v_d;
    end
  end

  assign done_o = done_q;
  assign z_o = z_q;
endmodule

>>> rtl/agdv_front.sv
// Input side: takes ciphertext words, numbers them within the message and
// queues them for the back end. Depends on agdv_pkg.
module agdv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 hold_i,
  input  logic [127:0]         cipher_i,
  input  logic                 last_i,
  output logic                 full_o,
  input  logic                 deq_i,
  output logic                 item_valid_o,
  output agdv_pkg::item_t      item_o
);
  import agdv_pkg::*;

  item_t q_q [QDEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [31:0] idx_q;
  logic acc;

  assign full_o = (cnt_q == 2'(QDEPTH)) || hold_i;
  assign acc = push_i && !full_o;
  assign item_valid_o = cnt_q != '0;
  assign item_o = q_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (acc) begin
        wp_q <= ~wp_q;
        idx_q <= last_i ? 32'd0 : idx_q + 32'd1;
      end
      if (deq_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(deq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_q[wp_q] <= '{cipher: cipher_i, last: last_i, count: idx_q + 32'd1};
  end
endmodule

>>> rtl/agdv_back.sv
// Back end: sequences the AES core and GHASH multiplier per word, keeps the
// hash key and accumulator, and queues results. Depends on agdv_pkg.
module agdv_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rekey_i,
  input  logic [127:0]            key_i,
  input  logic [95:0]             nonce_i,
  input  logic [127:0]            tag_i,
  input  logic                    item_valid_i,
  input  agdv_pkg::item_t         item_i,
  output logic                    deq_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output agdv_pkg::result_t       res_o,
  output agdv_pkg::back_stat_t    stat_o
);
  import agdv_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REKEY = 3'd1;
  localparam logic [2:0] ST_BULK = 3'd2;
  localparam logic [2:0] ST_MID = 3'd3;
  localparam logic [2:0] ST_LEN = 3'd4;
  localparam logic [2:0] ST_TAG = 3'd5;

  logic [2:0] st_q, st_d;
  logic pend_q, af_q, gf_q, a_ok, g_ok;
  logic [127:0] h_q, acc_q, ks_q, mask_q;
  item_t it_q;

  logic aes_start, aes_done, gh_start, gh_done;
  logic [127:0] aes_blk, aes_res, gh_x, gh_z;
  logic [31:0] ctr;

  result_t oq_q [QDEPTH];
  logic owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic opush, opop;
  result_t ores;

  agdv_aes u_aes (
    .clk_i, .rst_ni, .start_i(aes_start), .block_i(aes_blk), .key_i,
    .done_o(aes_done), .result_o(aes_res)
  );

  agdv_ghash u_gh (
    .clk_i, .rst_ni, .start_i(gh_start), .x_i(gh_x), .h_i(h_q),
    .done_o(gh_done), .z_o(gh_z)
  );

  assign ctr = (item_i.count + 32'd1) & CTR_MASK;
  assign a_ok = af_q || aes_done;
  assign g_ok = gf_q || gh_done;

  always_comb begin
    st_d = st_q;
    aes_start = 1'b0;
    aes_blk = {nonce_i, ctr};
    gh_start = 1'b0;
    gh_x = acc_q ^ item_i.cipher;
    deq_o = 1'b0;
    opush = 1'b0;
    ores = '{plain: it_q.cipher ^ ks_q, msg_end: 1'b0, match: 1'b0};
    case (st_q)
      ST_IDLE: begin
        if (pend_q) begin
          aes_start = 1'b1;
          aes_blk = '0;
          st_d = ST_REKEY;
        end else if (item_valid_i && ocnt_q != 2'(QDEPTH)) begin
          aes_start = 1'b1;
          gh_start = 1'b1;
          deq_o = 1'b1;
          st_d = ST_BULK;
        end
      end
      ST_REKEY: begin
        if (aes_done) st_d = ST_IDLE;
      end
      ST_BULK: begin
        if (a_ok && g_ok) st_d = ST_MID;
      end
      ST_MID: begin
        if (it_q.last) begin
          aes_start = 1'b1;
          aes_blk = {nonce_i, 32'd1};
          gh_start = 1'b1;
          gh_x = acc_q ^ {89'h0, it_q.count, 7'h0};
          st_d = ST_LEN;
        end else begin
          opush = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_LEN: begin
        if (a_ok && g_ok) st_d = ST_TAG;
      end
      ST_TAG: begin
        opush = 1'b1;
        ores.msg_end = 1'b1;
        ores.match = (acc_q ^ mask_q) == tag_i;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      pend_q <= 1'b1;
      af_q <= 1'b0;
      gf_q <= 1'b0;
      acc_q <= '0;
    end else begin
      st_q <= st_d;
      if (rekey_i) pend_q <= 1'b1;
      else if (st_q == ST_IDLE && pend_q) pend_q <= 1'b0;
      if (aes_start || gh_start) begin
        af_q <= 1'b0;
        gf_q <= 1'b0;
      end else begin
        if (aes_done) af_q <= 1'b1;
        if (gh_done) gf_q <= 1'b1;
      end
      if (gh_done) acc_q <= gh_z;
      else if (st_q == ST_TAG) acc_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_o) it_q <= item_i;
    if (aes_done) begin
      case (st_q)
        ST_REKEY: h_q <= aes_res;
        ST_LEN: mask_q <= aes_res;
        default: ks_q <= aes_res;
      endcase
    end
  end

  // Result queue.
  assign opop = pop_i && !empty_o;
  assign empty_o = ocnt_q == '0;
  assign res_o = oq_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= 1'b0;
      orp_q <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (opush) owp_q <= ~owp_q;
      if (opop) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owp_q] <= ores;
  end

  assign stat_o = '{rekey_busy: pend_q || st_q == ST_REKEY, oq_count: ocnt_q};
endmodule

>>> rtl/aes128_gcm_decrypt_verify_unit.sv
// Top level of the AES-128-GCM decrypt-and-verify unit: configuration
// registers, front end and back end. Depends on agdv_pkg, agdv_front, agdv_back.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            cipher_high_i, cipher_low_i, final_block_i
//   result    out        empty / pop            plain_high_o, plain_low_o, message_end_o,
//                                               tag_match_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// For a word that is not the last of its message, the time in the back end
// is set by the GHASH multiplier, which handles eight bits a cycle, while the
// AES core runs beside it. The last word of a message adds a length-block
// multiply and the E(K,J0) encryption, which run in parallel. After reset,
// and after each key write, the hash key is recomputed; full is high and
// cfg_ready_o low during that time. Two input words and two results can wait
// in queues, so either side may stall without stopping the other at once.
module aes128_gcm_decrypt_verify_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  input  logic        final_block_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] plain_high_o,
  output logic [63:0] plain_low_o,
  output logic        message_end_o,
  output logic        tag_match_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import agdv_pkg::*;

  logic [63:0] key_hi_q, key_lo_q, nonce_hi_q, tag_hi_q, tag_lo_q;
  logic [31:0] nonce_lo_q;
  logic cfg_wr, rekey, deq, item_valid;
  item_t item;
  result_t res;
  back_stat_t stat;

  // Configuration writes land at once; a key write also starts a rekey pass.
  assign cfg_ready_o = !stat.rekey_busy;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  assign rekey = cfg_wr && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      nonce_hi_q <= '0;
      nonce_lo_q <= '0;
      tag_hi_q <= '0;
      tag_lo_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
        CFG_KEY_LOW: key_lo_q <= cfg_data_i;
        CFG_NONCE_HIGH: nonce_hi_q <= cfg_data_i;
        CFG_NONCE_LOW: nonce_lo_q <= cfg_data_i[31:0];
        CFG_TAG_HIGH: tag_hi_q <= cfg_data_i;
        CFG_TAG_LOW: tag_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  agdv_front u_front (
    .clk_i, .rst_ni,
    .push_i(push),
    .hold_i(stat.rekey_busy),
    .cipher_i({cipher_high_i, cipher_low_i}),
    .last_i(final_block_i),
    .full_o(full),
    .deq_i(deq),
    .item_valid_o(item_valid),
    .item_o(item)
  );

  agdv_back u_back (
    .clk_i, .rst_ni,
    .rekey_i(rekey),
    .key_i({key_hi_q, key_lo_q}),
    .nonce_i({nonce_hi_q, nonce_lo_q}),
    .tag_i({tag_hi_q, tag_lo_q}),
    .item_valid_i(item_valid),
    .item_i(item),
    .deq_o(deq),
    .pop_i(pop),
    .empty_o(empty),
    .res_o(res),
    .stat_o(stat)
  );

  assign plain_high_o = res.plain[127:64];
  assign plain_low_o = res.plain[63:0];
  assign message_end_o = res.msg_end;
  assign tag_match_o = res.match;

  // A verdict is only ever given on the last word of a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !message_end_o) |-> !tag_match_o)
    else $error("tag match flagged on a word that does not end a message");

  // A key write must block new words and further writes while H is rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rekey |=> (full && !cfg_ready_o))
    else $error("input or config open right after a key write");

  // The result queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.oq_count <= 2'(QDEPTH))
    else $error("result queue overflow");
endmodule
